// ===== rtl/s256sh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s256sh_pkg
// Shared types, constants and SHA-256 helper functions for the stream hasher.
// ----------------------------------------------------------------------------
package s256sh_pkg;

  // input word: message byte or finish request
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  // output word: one 64-bit slice of the digest
  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // input mode codes
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // block buffer operations for one cycle
  typedef struct packed {
    logic load_byte;
    logic pad;
    logic set_len;
    logic clear_low;
    logic shift;
  } sched_op_t;

  // round unit requests and status
  typedef struct packed {
    logic start;
    logic init;
  } round_ctrl_t;

  typedef struct packed {
    logic busy;
    logic rounding;
    logic done;
  } round_stat_t;

  localparam int unsigned ROUNDS = 64;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // initial hash, element 0 in the most significant position
  localparam logic [0:7][31:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with a single shared round unit.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the hasher is idle. The byte
// that fills a 64-byte block starts a compression, and the next word is taken
// after its 64 rounds and the chain update, one round per cycle in the shared
// round unit. A finish request pads the block and runs one compression, or
// two when fewer than 9 bytes of room remain in the block; the first digest
// word is offered once the last compression, started with the length write,
// has updated the chain. The digest is offered as four 64-bit words, H0:H1
// first, each held until taken. When the fourth word is taken the hasher
// returns to the initial hash and a zero byte count, ready for a new message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire s256sh_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output s256sh_pkg::out_item_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_PAD_ROUND, S_LEN, S_FIN_ROUND, S_OUT
  } state_t;

  state_t                  state;
  logic [63:0]             count;
  logic                    pad_extra;
  logic [1:0]              idx;
  logic [5:0]              pos;
  logic                    in_fire;
  logic                    out_fire;
  logic                    absorb;
  logic                    finish;
  logic                    need_extra;
  s256sh_pkg::sched_op_t   sop;
  s256sh_pkg::round_ctrl_t rctl;
  s256sh_pkg::round_stat_t rstat;
  logic [31:0]             w;
  logic [0:7][31:0]        chain;
  logic [0:3][63:0]        digest;

  assign pos        = count[5:0];
  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = (state == S_OUT);
  assign out_fire   = out_valid && out_ready;
  assign absorb     = in_fire && (in_data.mode == s256sh_pkg::MODE_ABSORB);
  assign finish     = in_fire && (in_data.mode == s256sh_pkg::MODE_FINISH);
  assign need_extra = (pos[5:3] == 3'b111);

  // buffer operations
  assign sop.load_byte = absorb;
  assign sop.pad       = finish;
  assign sop.set_len   = (state == S_LEN);
  assign sop.clear_low = pad_extra;
  assign sop.shift     = rstat.rounding;

  // round unit requests
  assign rctl.start = (absorb && (pos == 6'd63)) || (finish && need_extra)
                    || (state == S_LEN);
  assign rctl.init  = out_fire && (idx == 2'd3);

  s256sh_sched u_sched (
    .clk       (clk),
    .op        (sop),
    .pos       (pos),
    .data_byte (in_data.data_byte),
    .len_bits  ({count[60:0], 3'b000}),
    .w         (w)
  );

  s256sh_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (rctl),
    .w     (w),
    .stat  (rstat),
    .chain (chain)
  );

  // digest output straight from the chain registers
  assign digest               = chain;
  assign out_data.digest_word  = digest[idx];
  assign out_data.digest_index = idx;
  assign out_data.digest_last  = (idx == 2'd3);

  // message sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= 64'd0;
      pad_extra <= 1'b0;
      idx       <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (absorb) begin
            count <= count + 64'd1;
            if (pos == 6'd63) begin
              state <= S_ROUND;
            end
          end else if (finish) begin
            pad_extra <= need_extra;
            state     <= need_extra ? S_PAD_ROUND : S_LEN;
          end
        end
        S_ROUND: begin
          if (rstat.done) begin
            state <= S_IDLE;
          end
        end
        S_PAD_ROUND: begin
          if (rstat.done) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          state <= S_FIN_ROUND;
        end
        S_FIN_ROUND: begin
          if (rstat.done) begin
            idx   <= 2'd0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              count     <= 64'd0;
              pad_extra <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no new word while the round unit works
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rstat.busy |-> !in_ready)
    else $error("input accepted while round unit busy");

  // round completion only while the sequencer waits for it
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    rstat.done |-> (state == S_ROUND || state == S_PAD_ROUND || state == S_FIN_ROUND))
    else $error("unexpected round completion");

  // after the last digest word the hasher is fresh
  a_fresh_after_digest: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_data.digest_last) |=> (in_ready && count == 64'd0))
    else $error("hasher not reset after digest");

  // the digest is never offered while a compression runs
  a_out_idle_round: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !rstat.busy)
    else $error("digest offered during compression");

endmodule
`default_nettype wire

// ===== rtl/s256sh_sched.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s256sh_sched
// Block buffer of sixteen 32-bit words. Bytes and padding are written in
// place; during compression the buffer shifts as the message schedule window.
// ----------------------------------------------------------------------------
module s256sh_sched (
  input  wire logic                  clk,
  input  wire s256sh_pkg::sched_op_t op,
  input  wire logic [5:0]            pos,
  input  wire logic [7:0]            data_byte,
  input  wire logic [63:0]           len_bits,
  output logic [31:0]                w
);

  logic [31:0] win [16];
  logic [31:0] new_w;
  logic [3:0]  widx;
  logic [4:0]  shamt;
  logic [7:0]  ins_byte;
  logic [31:0] ins_word;

  // next schedule word from the window taps
  assign new_w = s256sh_pkg::small_s1(win[14]) + win[9]
               + s256sh_pkg::small_s0(win[1]) + win[0];

  // byte insert: first byte of a word clears the rest of it
  assign widx     = pos[5:2];
  assign shamt    = {~pos[1:0], 3'b000};
  assign ins_byte = op.pad ? s256sh_pkg::PAD_BYTE : data_byte;
  assign ins_word = ((pos[1:0] == 2'd0) ? 32'd0 : win[widx])
                  | ({24'd0, ins_byte} << shamt);

  assign w = win[0];

  // buffer update
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (op.shift) begin
        if (i == 15) begin
          win[i] <= new_w;
        end else begin
          win[i] <= win[4'(i + 1)];
        end
      end else if ((op.load_byte || op.pad) && (4'(i) == widx)) begin
        win[i] <= ins_word;
      end else if (op.pad && (4'(i) > widx)) begin
        win[i] <= 32'd0;
      end else if (op.set_len) begin
        if (i == 14) begin
          win[i] <= len_bits[63:32];
        end else if (i == 15) begin
          win[i] <= len_bits[31:0];
        end else if (op.clear_low) begin
          win[i] <= 32'd0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/s256sh_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s256sh_round
// Shared compression round unit: one SHA-256 round per cycle for 64 rounds,
// then the R_ADD state folds the working variables into the chain value.
// ----------------------------------------------------------------------------
module s256sh_round (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire s256sh_pkg::round_ctrl_t ctrl,
  input  wire logic [31:0]             w,
  output s256sh_pkg::round_stat_t      stat,
  output logic [0:7][31:0]             chain
);

  typedef enum logic [1:0] {R_IDLE, R_RUN, R_ADD} rstate_t;

  rstate_t          state;
  logic [5:0]       t;
  logic [0:7][31:0] v;
  logic [31:0]      ch;
  logic [31:0]      maj;
  logic [31:0]      t1;
  logic [31:0]      t2;

  // round function
  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + s256sh_pkg::big_s1(v[4]) + ch + s256sh_pkg::round_k(t) + w;
  assign t2  = s256sh_pkg::big_s0(v[0]) + maj;

  assign stat.busy     = (state != R_IDLE);
  assign stat.rounding = (state == R_RUN);
  assign stat.done     = (state == R_ADD);

  // sequencer, working variables and chain value
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      t     <= 6'd0;
      chain <= s256sh_pkg::INIT_HASH;
    end else begin
      case (state)
        R_IDLE: begin
          if (ctrl.init) begin
            chain <= s256sh_pkg::INIT_HASH;
          end
          if (ctrl.start) begin
            v     <= chain;
            t     <= 6'd0;
            state <= R_RUN;
          end
        end
        R_RUN: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          t    <= t + 6'd1;
          if (t == 6'(s256sh_pkg::ROUNDS - 1)) begin
            state <= R_ADD;
          end
        end
        R_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
